>>> design/fpvt_pkg.sv
// Package for the fixed-point vertex transform: payload types, widths and
// fixed-point helper functions. Depends on nothing.
package fpvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_BITS  = 32 + FRAC_BITS + 1;
    localparam int DCNT_W    = $clog2(DIV_BITS + 1);

    localparam logic MODE_LOAD      = 1'b0;
    localparam logic MODE_TRANSFORM = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [3:0]  entry_index;
        logic [31:0] entry_value;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_x;
        logic [31:0] result_y;
        logic [31:0] result_z;
        logic [31:0] result_w;
        logic        normalised;
    } out_item_t;

    function automatic logic [32:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? {1'b0, (~v) + 32'd1} : {1'b0, v};
    endfunction

    function automatic logic [31:0] signed_sat(input logic neg, input logic [63:0] mag);
        logic [63:0] m;
        m = mag;
        if (neg) begin
            if (m > 64'h8000_0000) m = 64'h8000_0000;
            signed_sat = 32'd0 - m[31:0];
        end else begin
            if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
            signed_sat = m[31:0];
        end
    endfunction

endpackage

>>> design/fpvt_lane.sv
// One output column lane: three rounded, saturated products plus the offset.
// Depends on fpvt_pkg. Two register stages: products, then the wrapped sum.
module fpvt_lane (
    input  logic        aclk,
    input  logic        adv,
    input  logic [31:0] px,
    input  logic [31:0] py,
    input  logic [31:0] pz,
    input  logic [31:0] m0,
    input  logic [31:0] m1,
    input  logic [31:0] m2,
    input  logic [31:0] m3,
    output logic [31:0] sum
);
    import fpvt_pkg::*;

    logic [63:0] prod_reg [3];
    logic        neg_reg  [3];
    logic [31:0] off_reg;
    logic [31:0] sum_reg;
    logic [31:0] t [3];
    logic [31:0] a [3];
    logic [31:0] b [3];

    assign a[0] = px; assign a[1] = py; assign a[2] = pz;
    assign b[0] = m0; assign b[1] = m1; assign b[2] = m2;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= {31'd0, mag32(a[i])} * {31'd0, mag32(b[i])};
                neg_reg[i]  <= a[i][31] ^ b[i][31];
            end
            off_reg <= m3;
            sum_reg <= off_reg + t[0] + t[1] + t[2];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t[i] = signed_sat(neg_reg[i],
                (prod_reg[i] + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        end
    end

    assign sum = sum_reg;
endmodule

>>> design/fpvt_div.sv
// Shared restoring divider: divides x, y, z by w in turn, one bit a cycle.
// Depends on fpvt_pkg. Quotient rounded half away from zero and saturated.
module fpvt_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic        done,
    output logic [31:0] quot
);
    import fpvt_pkg::*;

    logic [DIV_BITS-1:0] n_reg, q_reg;
    logic [DIV_BITS:0]   r_reg;
    logic [32:0]         d_reg;
    logic                neg_reg, busy_reg, done_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [DIV_BITS:0]   r_sh;
    logic [32:0]         den_mag;

    assign den_mag = mag32(den);
    assign r_sh = {r_reg[DIV_BITS-1:0], n_reg[DIV_BITS-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_BITS);
                n_reg    <= ({{(DIV_BITS-33){1'b0}}, mag32(num)} << FRAC_BITS)
                            + {{(DIV_BITS-33){1'b0}}, 1'b0, den_mag[32:1]};
                d_reg    <= den_mag;
                neg_reg  <= num[31] ^ den[31];
                r_reg    <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                n_reg <= n_reg << 1;
                if (r_sh >= {{(DIV_BITS-32){1'b0}}, d_reg}) begin
                    r_reg <= r_sh - {{(DIV_BITS-32){1'b0}}, d_reg};
                    q_reg <= {q_reg[DIV_BITS-2:0], 1'b1};
                end else begin
                    r_reg <= r_sh;
                    q_reg <= {q_reg[DIV_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = signed_sat(neg_reg, {{(64-DIV_BITS){1'b0}}, q_reg});
endmodule

>>> design/fixed_point_vertex_transform.sv
// Top level of the fixed-point vertex transform: matrix store, four column
// lanes, and the normalizing stage with a shared divider. Depends on fpvt_pkg.
//
//   channel  direction  ports                       payload
//   s_       in         s_valid s_ready s_data      fpvt_pkg::in_item_t
//   m_       out        m_valid m_ready m_data      fpvt_pkg::out_item_t
//
// A load item changes the matrix as soon as it is taken; a transform item
// flows through a two-stage lane pipeline, one per column. When w is one or
// zero the result passes the product, sum and output registers, and items
// may follow back to back. Otherwise the shared serial divider runs three
// quotients in turn, each a start, one step per quotient bit and a capture,
// and the lanes hold meanwhile once their last stage is full.
// Reset restores the identity matrix and empties the pipeline.
// A stalled output fills a one-entry skid register; the lanes hold only once
// it is full, so s_ready never depends on m_ready within the same cycle.
module fixed_point_vertex_transform (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fpvt_pkg::in_item_t   s_data,
    input  logic                 m_ready,
    output logic                 m_valid,
    output fpvt_pkg::out_item_t  m_data
);
    import fpvt_pkg::*;

    logic [31:0] mat_reg [16];
    logic [1:0]  vld_reg;          // lane stage occupancy
    logic        fin_reg;          // sums ready, awaiting normalize stage
    logic        adv;
    logic [31:0] sum [4];
    logic        out_vld_reg;
    out_item_t   out_reg;
    logic        skid_vld_reg;     // second result waiting behind the output
    out_item_t   skid_reg;
    logic        dv_busy_reg;      // normalizing in progress
    logic [1:0]  dsel_reg;
    logic [31:0] w_hold_reg, x_hold_reg, y_hold_reg, z_hold_reg;
    logic        dstart;
    logic [31:0] dnum, quot;
    logic        dbusy, ddone;
    logic        out_free, norm;
    logic        lane_out, div_out, res_wr;
    out_item_t   res_new;

    // Room for one more result as long as the skid register is empty.
    assign out_free = !skid_vld_reg;
    // The lanes advance unless their last stage is blocked.
    assign adv     = !(vld_reg[1] && (dv_busy_reg || !out_free));
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= (i % 5 == 0) ? (32'd1 << FRAC_BITS) : 32'd0;
        end else if (s_valid && s_ready && s_data.mode == MODE_LOAD) begin
            mat_reg[s_data.entry_index] <= s_data.entry_value;
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_lane
        fpvt_lane u_lane (
            .aclk(aclk), .adv(adv),
            .px(s_data.point_x), .py(s_data.point_y), .pz(s_data.point_z),
            .m0(mat_reg[j]), .m1(mat_reg[4 + j]), .m2(mat_reg[8 + j]),
            .m3(mat_reg[12 + j]), .sum(sum[j])
        );
    end

    assign norm   = (sum[3] != (32'd1 << FRAC_BITS)) && (sum[3] != 32'd0);
    assign dnum   = (dsel_reg == 2'd0) ? x_hold_reg :
                    (dsel_reg == 2'd1) ? y_hold_reg : z_hold_reg;
    assign dstart = dv_busy_reg && !dbusy && !ddone && dsel_reg != 2'd3
                    && !fin_reg;

    fpvt_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .num(dnum),
        .den(w_hold_reg), .busy(dbusy), .done(ddone), .quot(quot)
    );

    // A result comes either straight from the lanes or from the divider.
    assign lane_out = vld_reg[1] && adv && !norm;
    assign div_out  = dv_busy_reg && dsel_reg == 2'd3 && out_free;
    assign res_wr   = lane_out || div_out;
    assign res_new  = div_out ? '{x_hold_reg, y_hold_reg, z_hold_reg, w_hold_reg, 1'b1}
                              : '{sum[0], sum[1], sum[2], sum[3], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= 2'b00;
            dv_busy_reg <= 1'b0;
            fin_reg     <= 1'b0;
            dsel_reg    <= 2'd0;
        end else begin
            fin_reg <= 1'b0;
            if (adv)
                vld_reg <= {vld_reg[0], s_valid && s_data.mode == MODE_TRANSFORM};
            if (vld_reg[1] && adv && norm) begin
                dv_busy_reg <= 1'b1;
                fin_reg     <= 1'b1;
                dsel_reg    <= 2'd0;
                x_hold_reg  <= sum[0];
                y_hold_reg  <= sum[1];
                z_hold_reg  <= sum[2];
                w_hold_reg  <= sum[3];
            end
            if (ddone) begin
                case (dsel_reg)
                    2'd0:    x_hold_reg <= quot;
                    2'd1:    y_hold_reg <= quot;
                    default: z_hold_reg <= quot;
                endcase
                dsel_reg <= dsel_reg + 2'd1;
            end
            if (div_out)
                dv_busy_reg <= 1'b0;
        end
    end

    // Output register with a one-entry skid behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_vld_reg && m_ready) begin
            if (skid_vld_reg) begin
                out_reg      <= skid_reg;
                skid_vld_reg <= 1'b0;
            end else if (res_wr) begin
                out_reg <= res_new;
            end else begin
                out_vld_reg <= 1'b0;
            end
        end else if (!out_vld_reg) begin
            if (res_wr) begin
                out_vld_reg <= 1'b1;
                out_reg     <= res_new;
            end
        end else if (res_wr) begin
            skid_vld_reg <= 1'b1;
            skid_reg     <= res_new;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // A finished result is never overwritten while it waits.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");
    // The divider only starts while a normalizing item is held.
    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        dstart |-> dv_busy_reg)
        else $error("divider started without an item");
    // No input is taken while the lane output waits for the divider.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[1] && dv_busy_reg) |-> !s_ready)
        else $error("input taken while blocked");
endmodule

>>> test/tb.sv
// Testbench for the fixed-point vertex transform: a directed table, then random
// load and transform items, each result checked against a local predictor.
// Depends on fpvt_pkg and fixed_point_vertex_transform.
module tb;
    import fpvt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_ITEMS   = 700;
    localparam logic [31:0] FX_ONE = 32'h0001_0000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_ready;
    logic      m_valid;
    out_item_t m_data;

    fixed_point_vertex_transform DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // Clock with a period of 10 time units.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // The predictor keeps its own copy of the matrix.
    logic [31:0] shadow_matrix [16];
    out_item_t   pending_results [$];
    int          failures;
    int          idle_cycles;
    bit          draining;

    function automatic logic [63:0] magnitude(input logic [31:0] v);
        return v[31] ? {32'd0, (~v) + 32'd1} : {32'd0, v};
    endfunction

    function automatic logic [31:0] clamp_signed(input logic neg, input logic [63:0] mag);
        if (neg) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return 32'd0 - mag[31:0];
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic logic [31:0] fx_product(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] m;
        m = magnitude(a) * magnitude(b);
        m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return clamp_signed(a[31] ^ b[31], m);
    endfunction

    function automatic logic [31:0] fx_quotient(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] mb;
        logic [63:0] q;
        mb = magnitude(b);
        if (mb == 0) return a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        q = ((magnitude(a) << FRAC_BITS) + (mb >> 1)) / mb;
        return clamp_signed(a[31] ^ b[31], q);
    endfunction

    function automatic void reset_matrix();
        for (int i = 0; i < 16; i++) shadow_matrix[i] = (i % 5 == 0) ? FX_ONE : 32'd0;
    endfunction

    // Applies one accepted item to the shadow matrix or predicts its result.
    function automatic void predict_vertex(input in_item_t it);
        logic [31:0] r [4];
        logic [31:0] p [3];
        out_item_t   res;
        if (it.mode == MODE_LOAD) begin
            shadow_matrix[it.entry_index] = it.entry_value;
            return;
        end
        p[0] = it.point_x;
        p[1] = it.point_y;
        p[2] = it.point_z;
        for (int j = 0; j < 4; j++) begin
            r[j] = shadow_matrix[12 + j];
            for (int i = 0; i < 3; i++) r[j] += fx_product(p[i], shadow_matrix[i * 4 + j]);
        end
        res.normalised = (r[3] != FX_ONE) && (r[3] != 32'd0);
        if (res.normalised) begin
            for (int j = 0; j < 3; j++) r[j] = fx_quotient(r[j], r[3]);
        end
        res.result_x = r[0];
        res.result_y = r[1];
        res.result_z = r[2];
        res.result_w = r[3];
        pending_results.push_back(res);
    endfunction

    // Directed table: mode, index, value, x, y, z, and an optional typed-in result.
    typedef struct {
        in_item_t  item;
        bit        has_fixed;
        out_item_t fixed;
    } directed_row_t;

    directed_row_t vertex_table [$];

    function automatic in_item_t make_item(input logic m, input logic [3:0] idx,
                                           input logic [31:0] v, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
        in_item_t it;
        it.mode = m;
        it.entry_index = idx;
        it.entry_value = v;
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        return it;
    endfunction

    task automatic add_row(input in_item_t it, input bit fixed_known, input out_item_t fr);
        directed_row_t row;
        row.item = it;
        row.has_fixed = fixed_known;
        row.fixed = fr;
        vertex_table.push_back(row);
    endtask

    task automatic build_table();
        out_item_t none;
        out_item_t r;
        none = '0;
        // Identity after reset: the point passes unchanged, w stays one.
        r = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, FX_ONE, 1'b0};
        add_row(make_item(MODE_TRANSFORM, 4'hF, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h0), 1, r);
        r = '{32'h0001_8000, 32'hFFFF_0000, 32'h0000_0001, FX_ONE, 1'b0};
        add_row(make_item(MODE_TRANSFORM, 4'h0, 32'h0,
                          32'h0001_8000, 32'hFFFF_0000, 32'h1), 1, r);
        // Product overflow: a large scale saturates before the wrapping sum.
        add_row(make_item(MODE_LOAD, 4'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, none);
        add_row(make_item(MODE_LOAD, 4'd5, 32'h8000_0000, 0, 0, 0), 0, none);
        add_row(make_item(MODE_TRANSFORM, 4'd0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1),
                0, none);
        add_row(make_item(MODE_TRANSFORM, 4'd0, 0, 32'h8000_0000, 32'h8000_0000,
                          32'hFFFF_FFFF), 0, none);
        // Sum overflow through the translation row.
        add_row(make_item(MODE_LOAD, 4'd12, 32'h7FFF_FFFF, 0, 0, 0), 0, none);
        add_row(make_item(MODE_TRANSFORM, 4'd0, 0, 32'h0001_0000, 0, 0), 0, none);
        // W zero: no division.
        add_row(make_item(MODE_LOAD, 4'd15, 32'h0, 0, 0, 0), 0, none);
        add_row(make_item(MODE_TRANSFORM, 4'd0, 0, 32'h0002_0000, 32'h0003_0000, 32'h1_0000),
                0, none);
        // W taken from z: division, including a small w that saturates the quotient.
        add_row(make_item(MODE_LOAD, 4'd11, FX_ONE, 0, 0, 0), 0, none);
        add_row(make_item(MODE_TRANSFORM, 4'd0, 0, 32'h0004_0000, 32'hFFFD_0000, 32'h0002_0000),
                0, none);
        add_row(make_item(MODE_TRANSFORM, 4'd0, 0, 32'h7FFF_0000, 32'h8000_0000, 32'h0000_0001),
                0, none);
        add_row(make_item(MODE_TRANSFORM, 4'd0, 0, 32'h0000_0003, 32'hFFFF_FFFD, 32'hFFFE_0000),
                0, none);
        add_row(make_item(MODE_TRANSFORM, 4'd0, 0, 32'h0001_0000, 32'h1_0000, 32'h8000_0000),
                0, none);
        // Restore the identity, touching every entry once.
        for (int i = 0; i < 16; i++) begin
            add_row(make_item(MODE_LOAD, i[3:0], (i % 5 == 0) ? FX_ONE : 32'd0,
                              32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF), 0, none);
        end
    endtask

    function automatic logic [31:0] random_fixed();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000 +
                      ($urandom_range(0, 8) << 16) - 32'h0004_0000;
            default: return 32'($signed($urandom_range(0, 16'hFFFF))) +
                            (32'($urandom_range(0, 12)) << 16) - 32'h0006_0000;
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.mode        = ($urandom_range(0, 99) < 35) ? MODE_LOAD : MODE_TRANSFORM;
        it.entry_index = 4'($urandom_range(0, 15));
        it.entry_value = random_fixed();
        it.point_x     = random_fixed();
        it.point_y     = random_fixed();
        it.point_z     = random_fixed();
        // Keep w on one or zero much of the time so both paths are exercised.
        if (it.mode == MODE_LOAD && it.entry_index == 4'd15 && $urandom_range(0, 1))
            it.entry_value = $urandom_range(0, 1) ? FX_ONE : 32'd0;
        if (it.mode == MODE_LOAD && it.entry_index inside {4'd3, 4'd7, 4'd11} &&
            $urandom_range(0, 2) == 0)
            it.entry_value = 32'd0;
        return it;
    endfunction

    // Sends one item after a random gap and holds it until it is taken.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_vertex(it);
        @(negedge aclk);
    endtask

    // Receiver: random stalls, results compared at the rising edge.
    initial begin
        int stall;
        out_item_t want;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (m_data !== want) begin
                    $display("%0t: mismatch expected x=%h y=%h z=%h w=%h n=%b",
                             $time, want.result_x, want.result_y, want.result_z,
                             want.result_w, want.normalised);
                    $display("%0t:          actual   x=%h y=%h z=%h w=%h n=%b",
                             $time, m_data.result_x, m_data.result_y, m_data.result_z,
                             m_data.result_w, m_data.normalised);
                    failures++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no item is accepted on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || draining)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("fixed_point_vertex_transform test failed");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random items, drain.
    initial begin
        out_item_t want;
        failures = 0;
        draining = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        reset_matrix();
        build_table();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (vertex_table[k]) begin
            send_item(vertex_table[k].item);
            // Rows with a result read straight off the model replace the prediction.
            if (vertex_table[k].has_fixed) begin
                want = pending_results.pop_back();
                if (want !== vertex_table[k].fixed) begin
                    $display("%0t: table row %0d predicted %p, typed %p",
                             $time, k, want, vertex_table[k].fixed);
                    failures++;
                end
                pending_results.push_back(vertex_table[k].fixed);
            end
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) send_item(random_item());
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        draining = 1;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0 && pending_results.size() == 0)
            $display("fixed_point_vertex_transform test passed");
        else
            $display("fixed_point_vertex_transform test failed");
        $finish;
    end
endmodule
